// ===== design/asa_pkg.sv =====
// Shared widths, register indexes and CORDIC arctangent table for the steering angle unit.
package asa_pkg;
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ZW   = 33;
  localparam int MW   = 48;
  localparam int VW   = 50;
  localparam int SHF  = 30 - ANGLE_FRAC_BITS;
  localparam int AW   = ANGLE_FRAC_BITS + 2;
  localparam int AWR  = ZW - SHF;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [AWR-1:0] ANG_LIM =
    AWR'((HALF_PI_Q30 + (ZW'(1) <<< (SHF - 1))) >>> SHF);
  localparam logic signed [ZW-1:0] ATAN_Q30 [0:23] = '{
    33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159, 33'sd67021687,
    33'sd33543516, 33'sd16775851, 33'sd8388437, 33'sd4194283, 33'sd2097149,
    33'sd1048576, 33'sd524288, 33'sd262144, 33'sd131072, 33'sd65536, 33'sd32768,
    33'sd16384, 33'sd8192, 33'sd4096, 33'sd2048, 33'sd1024, 33'sd512, 33'sd256,
    33'sd128};

  typedef enum logic [1:0] {
    REG_WHEELBASE = 2'd0,
    REG_TRACK     = 2'd1,
    REG_SPIN_GAIN = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic zero;
    logic half;
  } vec_flag_t;
endpackage

// ===== design/asa_if.sv =====
// Valid/ready channel interfaces for commands and results.
interface asa_in_if;
  logic              valid;
  logic              ready;
  logic signed [14:0] steer_angle;
  logic signed [15:0] velocity;
  modport source (output valid, steer_angle, velocity, input ready);
  modport sink   (input valid, steer_angle, velocity, output ready);
endinterface

interface asa_out_if;
  logic              valid;
  logic              ready;
  logic signed [14:0] right_wheel_angle;
  logic signed [14:0] left_wheel_angle;
  logic signed [15:0] wheel_spin;
  logic              spin_saturated;
  modport source (output valid, right_wheel_angle, left_wheel_angle, wheel_spin,
                  spin_saturated, input ready);
  modport sink   (input valid, right_wheel_angle, left_wheel_angle, wheel_spin,
                  spin_saturated, output ready);
endinterface

// ===== design/asa_vec.sv =====
// Pipelined vectoring CORDIC: arctangent of y/x, one stage per iteration.
module asa_vec (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [asa_pkg::VW-1:0] x_in,
  input  logic signed [asa_pkg::VW-1:0] y_in,
  input  asa_pkg::vec_flag_t            flag_in,
  output logic signed [asa_pkg::ZW-1:0] z_out,
  output asa_pkg::vec_flag_t            flag_out
);
  import asa_pkg::*;

  logic signed [VW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [VW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [0:CORDIC_STEPS];
  vec_flag_t            f_r [0:CORDIC_STEPS];

  always_comb begin
    x_r[0] = x_in;
    y_r[0] = y_in;
    z_r[0] = '0;
    f_r[0] = flag_in;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_Q30[i];
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_Q30[i];
        end
        f_r[i+1] <= f_r[i];
      end
    end
  end

  assign z_out    = z_r[CORDIC_STEPS];
  assign flag_out = f_r[CORDIC_STEPS];
endmodule

// ===== design/ackermann_steer_angles_unit.sv =====
// Top level: Ackermann wheel angles and drive spin, fully pipelined.
// channel | dir | transaction
// in_chan  | in  | steer_angle, velocity
// out_chan | out | right/left wheel angle, wheel_spin, spin_saturated
// cfg_*    | in  | register write, no handshake
// Accepts one transaction per cycle unless out_chan stalls; each result passes through
// the rotation CORDIC, the multiply and prep stages and the vectoring CORDIC.
// rst_n (synchronous) clears valid bits and restores register defaults.
// A stall on out_chan freezes the whole pipeline; nothing is lost or repeated.
module ackermann_steer_angles_unit (
  input  logic         clk,
  input  logic         rst_n,
  asa_in_if.sink       in_chan,
  asa_out_if.source    out_chan,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [15:0]  cfg_data
);
  import asa_pkg::*;

  localparam int N     = CORDIC_STEPS;
  localparam int SBLEN = 2 * N + 3;

  typedef struct packed {
    logic               vld;
    logic               dzero;
    logic signed [15:0] spin;
    logic               sat;
  } sb_t;

  logic [11:0] wb_r, tr_r;
  logic [15:0] gain_r;
  logic        en;

  assign en = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r   <= 12'd500;
      tr_r   <= 12'd400;
      gain_r <= 16'd1422;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_WHEELBASE: wb_r   <= cfg_data[11:0];
        REG_TRACK:     tr_r   <= cfg_data[11:0];
        REG_SPIN_GAIN: gain_r <= cfg_data;
        REG_NONE:      ;
        default:       ;
      endcase
    end
  end

  // stage 0: clamp angle, spin product
  logic signed [14:0] d_c;
  logic signed [32:0] prod_r;
  logic               v0_r, dz0_r;
  logic signed [ZW-1:0] rc_r [0:N];
  logic signed [ZW-1:0] rs_r [0:N];
  logic signed [ZW-1:0] rz_r [0:N];

  always_comb begin
    if (in_chan.steer_angle > 15'(ANG_LIM))       d_c = 15'(ANG_LIM);
    else if (in_chan.steer_angle < -15'(ANG_LIM)) d_c = -15'(ANG_LIM);
    else                                         d_c = in_chan.steer_angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_chan.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz0_r    <= (d_c == '0);
      prod_r   <= 33'(in_chan.velocity) * $signed({17'd0, gain_r});
      rc_r[0]  <= ZW'(1) <<< 30;
      rs_r[0]  <= '0;
      rz_r[0]  <= ZW'(d_c) <<< SHF;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        if (rz_r[i] >= 0) begin
          rc_r[i+1] <= rc_r[i] - (rs_r[i] >>> i);
          rs_r[i+1] <= rs_r[i] + (rc_r[i] >>> i);
          rz_r[i+1] <= rz_r[i] - ATAN_Q30[i];
        end else begin
          rc_r[i+1] <= rc_r[i] + (rs_r[i] >>> i);
          rs_r[i+1] <= rs_r[i] - (rc_r[i] >>> i);
          rz_r[i+1] <= rz_r[i] + ATAN_Q30[i];
        end
      end
    end
  end

  // side-band line: valid, zero-angle flag, spin and its saturation flag
  sb_t sb_r [1:SBLEN-1];
  sb_t sb1_nxt;
  logic signed [24:0] spin_rnd;

  always_comb begin
    spin_rnd = 25'((prod_r + 33'sd128) >>> 8);
    sb1_nxt.vld   = v0_r;
    sb1_nxt.dzero = dz0_r;
    if (spin_rnd > 25'sd32767) begin
      sb1_nxt.spin = 16'sd32767;
      sb1_nxt.sat  = 1'b1;
    end else if (spin_rnd < -25'sd32768) begin
      sb1_nxt.spin = -16'sd32768;
      sb1_nxt.sat  = 1'b1;
    end else begin
      sb1_nxt.spin = 16'(spin_rnd);
      sb1_nxt.sat  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k < SBLEN; k++) sb_r[k].vld <= 1'b0;
    end else if (en) begin
      sb_r[1] <= sb1_nxt;
      for (int k = 2; k < SBLEN; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  // multiply stage
  logic signed [MW-1:0] num_r, base_r, side_r;
  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= (MW'($signed({1'b0, wb_r})) * MW'(rs_r[N])) <<< 1;
      base_r <= (MW'($signed({1'b0, wb_r})) * MW'(rc_r[N])) <<< 1;
      side_r <= MW'($signed({1'b0, tr_r})) * MW'(rs_r[N]);
    end
  end

  // prep stage
  logic signed [MW-1:0] den_rt, den_lt;
  logic signed [VW-1:0] xr_r, yr_r, xl_r, yl_r;
  vec_flag_t            fr_r, fl_r;

  assign den_rt = base_r + side_r;
  assign den_lt = base_r - side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xr_r <= (den_rt < 0) ? -VW'(den_rt) : VW'(den_rt);
      yr_r <= (den_rt < 0) ? -VW'(num_r)  : VW'(num_r);
      xl_r <= (den_lt < 0) ? -VW'(den_lt) : VW'(den_lt);
      yl_r <= (den_lt < 0) ? -VW'(num_r)  : VW'(num_r);
      fr_r.zero <= sb_r[N+1].dzero || (num_r == '0);
      fr_r.half <= (den_rt == '0);
      fl_r.zero <= sb_r[N+1].dzero || (num_r == '0);
      fl_r.half <= (den_lt == '0);
    end
  end

  logic signed [ZW-1:0] zr, zl;
  vec_flag_t            fro, flo;

  asa_vec u_vec_right (
    .clk(clk), .en(en), .x_in(xr_r), .y_in(yr_r), .flag_in(fr_r),
    .z_out(zr), .flag_out(fro)
  );
  asa_vec u_vec_left (
    .clk(clk), .en(en), .x_in(xl_r), .y_in(yl_r), .flag_in(fl_r),
    .z_out(zl), .flag_out(flo)
  );

  // output stage
  logic signed [ZW-1:0]  zr_sel, zl_sel;
  logic signed [AWR-1:0] ar, al;
  logic signed [14:0]    ar_c, al_c;

  always_comb begin
    zr_sel = fro.zero ? '0 : (fro.half ? HALF_PI_Q30 : zr);
    zl_sel = flo.zero ? '0 : (flo.half ? HALF_PI_Q30 : zl);
    ar = AWR'((zr_sel + (ZW'(1) <<< (SHF - 1))) >>> SHF);
    al = AWR'((zl_sel + (ZW'(1) <<< (SHF - 1))) >>> SHF);
    if (ar > ANG_LIM)       ar_c = 15'(ANG_LIM);
    else if (ar < -ANG_LIM) ar_c = -15'(ANG_LIM);
    else                    ar_c = 15'(ar);
    if (al > ANG_LIM)       al_c = 15'(ANG_LIM);
    else if (al < -ANG_LIM) al_c = -15'(ANG_LIM);
    else                    al_c = 15'(al);
  end

  logic               ov_r, osat_r;
  logic signed [14:0] oar_r, oal_r;
  logic signed [15:0] ospin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= sb_r[SBLEN-1].vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oar_r   <= ar_c;
      oal_r   <= al_c;
      ospin_r <= sb_r[SBLEN-1].spin;
      osat_r  <= sb_r[SBLEN-1].sat;
    end
  end

  assign out_chan.valid             = ov_r;
  assign out_chan.right_wheel_angle = oar_r;
  assign out_chan.left_wheel_angle  = oal_r;
  assign out_chan.wheel_spin        = ospin_r;
  assign out_chan.spin_saturated    = osat_r;
endmodule
